@@ rtl/mpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types, codes and the byte classifier of the word matcher.
// ----------------------------------------------------------------------------
package mpwm_pkg;

  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned STATE_W     = 10;
  localparam int unsigned START_W     = 13;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned CLASS_COUNT = 37;
  localparam int unsigned CLASS_W     = 6;
  localparam int unsigned WALK_W      = 16;

  localparam logic [ACTION_W-1:0] ACT_WR_TRANS = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WR_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_WR_ID    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TEXT     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_END      = 3'd4;

  localparam logic [BYTE_W-1:0] CHR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CHR_LO_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CHR_LO_Z  = 8'h7a;
  localparam logic [BYTE_W-1:0] CHR_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_UP_Z  = 8'h5a;

  localparam logic [CLASS_W-1:0] CLS_SEP    = 6'd0;
  localparam logic [CLASS_W-1:0] CLS_DIGIT  = 6'd1;
  localparam logic [CLASS_W-1:0] CLS_LETTER = 6'd11;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ROOT,
    SEQ_TRANS,
    SEQ_START_B,
    SEQ_START_E,
    SEQ_EMIT
  } seq_state_t;

  function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
    logic [CLASS_W-1:0] c;
    c = CLS_SEP;
    if (b >= CHR_0 && b <= CHR_9) begin
      c = CLASS_W'(b - CHR_0) + CLS_DIGIT;
    end else if (b >= CHR_LO_A && b <= CHR_LO_Z) begin
      c = CLASS_W'(b - CHR_LO_A) + CLS_LETTER;
    end else if (b >= CHR_UP_A && b <= CHR_UP_Z) begin
      c = CLASS_W'(b - CHR_UP_A) + CLS_LETTER;
    end
    return c;
  endfunction

endpackage

@@ rtl/multi_pattern_word_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_word_matcher
// Aho-Corasick DFA word matcher over host-loaded tables.
// ----------------------------------------------------------------------------
// Table writes leave the matcher idle. A text byte or end of text that enters a
// state runs the dependent chain transition read -> two output start reads ->
// id read, each on a memory with one registered read port, after a root
// transition read on the first byte of a text; then one hit per cycle while
// out_ready is high. A skipped separator or an end of text with nothing to flush
// leaves the matcher idle; a separator at text start passes through the root
// state. Tables hold no reset value and need no clearing pass. A waiting result
// sits in the output register while the next request is accepted.
module multi_pattern_word_matcher #(
  parameter int unsigned STATE_LIMIT = 1024,
  parameter int unsigned HIT_STORE   = 4096,
  parameter int unsigned MAX_HITS    = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mpwm_pkg::COUNT_W-1:0]    cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mpwm_pkg::ACTION_W-1:0]   in_action,
  input  logic [mpwm_pkg::INDEX_W-1:0]    in_table_index,
  input  logic [mpwm_pkg::VALUE_W-1:0]    in_table_value,
  input  logic [mpwm_pkg::BYTE_W-1:0]     in_text_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpwm_pkg::ID_W-1:0]       out_rule_id,
  output logic                            out_last_hit
);

  import mpwm_pkg::*;

  localparam int unsigned TRANS_DEPTH  = STATE_LIMIT * CLASS_COUNT;
  localparam int unsigned STARTS_DEPTH = STATE_LIMIT + 1;
  localparam int unsigned TA_W         = $clog2(TRANS_DEPTH);
  localparam int unsigned SA_W         = $clog2(STARTS_DEPTH);
  localparam int unsigned IA_W         = $clog2(HIT_STORE);
  localparam int unsigned NCNT_W       = $clog2(MAX_HITS + 1);

  seq_state_t state_r, state_nxt;

  logic [COUNT_W-1:0] sc_r;
  logic [STATE_W-1:0] cur_r;
  logic               pws_r;
  logic               ats_r;
  logic               eot_r;
  logic [CLASS_W-1:0] cls_r;
  logic [STATE_W-1:0] ns_r;
  logic [START_W-1:0] b_r;
  logic [START_W-1:0] e_r;
  logic [START_W-1:0] k_r;
  logic [NCNT_W-1:0]  n_r;
  logic               trans_oor_r;
  logic               start_oor_r;
  logic               id_oor_r;
  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_last_r;

  logic               in_fire;
  logic               text_go;
  logic               end_go;
  logic               flush_ok;
  logic [CLASS_W-1:0] in_cls;
  logic               text_skip;
  logic [STATE_W-1:0] tr_q;
  logic [START_W-1:0] start_q;
  logic [STATE_W-1:0] walk_base;
  logic [CLASS_W-1:0] walk_cls;
  logic [WALK_W-1:0]  walk_idx;
  logic [31:0]        wr_idx32;
  logic [31:0]        trans_ptr32;
  logic [31:0]        start_ptr32;
  logic [31:0]        id_ptr32;
  logic [START_W:0]   k_inc;
  logic               out_load;
  logic               hit_last;

  logic               trans_we, trans_re;
  logic               start_we, start_re;
  logic               id_we, id_re;
  logic [STATE_W-1:0] trans_rdata;
  logic [START_W-1:0] start_rdata;
  logic [ID_W-1:0]    id_rdata;

  assign in_ready  = (state_r == SEQ_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign text_go   = in_fire && (in_action == ACT_TEXT) && (sc_r != '0);
  assign end_go    = in_fire && (in_action == ACT_END) && (sc_r != '0);
  assign flush_ok  = !ats_r && !pws_r;
  assign in_cls    = byte_class(in_text_byte);
  assign text_skip = (in_cls == CLS_SEP) && pws_r;

  assign tr_q    = trans_oor_r ? '0 : trans_rdata;
  assign start_q = start_oor_r ? '0 : start_rdata;

  assign walk_base = (state_r == SEQ_ROOT) ? tr_q : cur_r;
  assign walk_cls  = (state_r == SEQ_ROOT) ? cls_r :
                     ((in_action == ACT_END) ? CLS_SEP : in_cls);
  assign walk_idx  = WALK_W'(walk_base) * WALK_W'(CLASS_COUNT) + WALK_W'(walk_cls);
  assign wr_idx32  = 32'(in_table_index);

  assign k_inc    = {1'b0, k_r} + 1'b1;
  assign out_load = (state_r == SEQ_EMIT) && (!out_valid_r || out_ready);
  assign hit_last = (k_inc >= {1'b0, e_r}) || (n_r == NCNT_W'(MAX_HITS - 1));

  // table writes
  assign trans_we = in_fire && (in_action == ACT_WR_TRANS) && (wr_idx32 < TRANS_DEPTH);
  assign start_we = in_fire && (in_action == ACT_WR_START) && (wr_idx32 < STARTS_DEPTH);
  assign id_we    = in_fire && (in_action == ACT_WR_ID) && (wr_idx32 < HIT_STORE);

  // read sequencing
  always_comb begin
    trans_re    = 1'b0;
    trans_ptr32 = 32'(walk_idx);
    start_re    = 1'b0;
    start_ptr32 = 32'(tr_q);
    id_re       = 1'b0;
    id_ptr32    = 32'(k_inc);
    unique case (state_r)
      SEQ_IDLE: begin
        if (text_go && ats_r) begin
          trans_re    = 1'b1;
          trans_ptr32 = '0;
        end else if (text_go && !text_skip) begin
          trans_re = 1'b1;
        end else if (end_go && flush_ok) begin
          trans_re = 1'b1;
        end
      end
      SEQ_ROOT: begin
        trans_re = (cls_r != CLS_SEP);
      end
      SEQ_TRANS: begin
        start_re = 1'b1;
      end
      SEQ_START_B: begin
        start_re    = 1'b1;
        start_ptr32 = 32'(ns_r) + 32'd1;
      end
      SEQ_START_E: begin
        id_re    = (b_r < start_q);
        id_ptr32 = 32'(b_r);
      end
      SEQ_EMIT: begin
        id_re = out_load && !hit_last;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (text_go) begin
          if (ats_r) begin
            state_nxt = SEQ_ROOT;
          end else if (!text_skip) begin
            state_nxt = SEQ_TRANS;
          end
        end else if (end_go && flush_ok) begin
          state_nxt = SEQ_TRANS;
        end
      end
      SEQ_ROOT: begin
        state_nxt = (cls_r == CLS_SEP) ? SEQ_IDLE : SEQ_TRANS;
      end
      SEQ_TRANS: begin
        state_nxt = SEQ_START_B;
      end
      SEQ_START_B: begin
        state_nxt = SEQ_START_E;
      end
      SEQ_START_E: begin
        state_nxt = (b_r < start_q) ? SEQ_EMIT : SEQ_IDLE;
      end
      SEQ_EMIT: begin
        if (out_load && hit_last) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      sc_r        <= '0;
      cur_r       <= '0;
      pws_r       <= 1'b1;
      ats_r       <= 1'b1;
      eot_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        sc_r <= cfg_wdata;
      end
      if (text_go) begin
        eot_r <= 1'b0;
        if (ats_r) begin
          ats_r <= 1'b0;
          pws_r <= 1'b1;
        end else if (!text_skip) begin
          pws_r <= (in_cls == CLS_SEP);
        end
      end
      if (end_go) begin
        ats_r <= 1'b1;
        pws_r <= 1'b1;
        eot_r <= flush_ok;
        if (!flush_ok) begin
          cur_r <= '0;
        end
      end
      if (state_r == SEQ_ROOT) begin
        cur_r <= tr_q;
        if (cls_r != CLS_SEP) begin
          pws_r <= 1'b0;
        end
      end
      if (state_r == SEQ_TRANS) begin
        cur_r <= eot_r ? '0 : tr_q;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (text_go) begin
      cls_r <= in_cls;
    end
    if (trans_re) begin
      trans_oor_r <= (trans_ptr32 >= TRANS_DEPTH);
    end
    if (start_re) begin
      start_oor_r <= (start_ptr32 >= STARTS_DEPTH);
    end
    if (id_re) begin
      id_oor_r <= (id_ptr32 >= HIT_STORE);
    end
    if (state_r == SEQ_TRANS) begin
      ns_r <= tr_q;
    end
    if (state_r == SEQ_START_B) begin
      b_r <= start_q;
    end
    if (state_r == SEQ_START_E) begin
      e_r <= start_q;
      k_r <= b_r;
      n_r <= '0;
    end
    if (out_load) begin
      out_id_r   <= id_oor_r ? '0 : id_rdata;
      out_last_r <= hit_last;
      if (!hit_last) begin
        k_r <= k_inc[START_W-1:0];
        n_r <= n_r + 1'b1;
      end
    end
  end

  mpwm_ram #(
    .DEPTH  (TRANS_DEPTH),
    .WIDTH  (STATE_W),
    .ADDR_W (TA_W)
  ) u_trans (
    .clk   (clk),
    .we    (trans_we),
    .waddr (wr_idx32[TA_W-1:0]),
    .wdata (in_table_value[STATE_W-1:0]),
    .re    (trans_re),
    .raddr (trans_ptr32[TA_W-1:0]),
    .rdata (trans_rdata)
  );

  mpwm_ram #(
    .DEPTH  (STARTS_DEPTH),
    .WIDTH  (START_W),
    .ADDR_W (SA_W)
  ) u_starts (
    .clk   (clk),
    .we    (start_we),
    .waddr (wr_idx32[SA_W-1:0]),
    .wdata (in_table_value[START_W-1:0]),
    .re    (start_re),
    .raddr (start_ptr32[SA_W-1:0]),
    .rdata (start_rdata)
  );

  mpwm_ram #(
    .DEPTH  (HIT_STORE),
    .WIDTH  (ID_W),
    .ADDR_W (IA_W)
  ) u_ids (
    .clk   (clk),
    .we    (id_we),
    .waddr (wr_idx32[IA_W-1:0]),
    .wdata (in_table_value[ID_W-1:0]),
    .re    (id_re),
    .raddr (id_ptr32[IA_W-1:0]),
    .rdata (id_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_rule_id  = out_id_r;
  assign out_last_hit = out_last_r;

endmodule

@@ rtl/mpwm_ram.sv @@
// ----------------------------------------------------------------------------
// mpwm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mpwm_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mpwm_checker.sv @@
// ----------------------------------------------------------------------------
// mpwm_checker
// Port-level checks of the word matcher, bound to the top level.
// ----------------------------------------------------------------------------
module mpwm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mpwm_pkg::ID_W-1:0]     out_rule_id,
  input logic                          out_last_hit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rule_id) && $stable(out_last_hit))
    else $error("result changed while stalled");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left a result or busy");

  a_no_instant_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after a request");

  a_busy_when_hits: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !out_last_hit |-> !in_ready)
    else $error("request taken while hits of a request remain");

endmodule

bind multi_pattern_word_matcher mpwm_checker u_mpwm_checker (.*);
